[hw/rtl/ols_pkg.sv]
// Shared types and constants for the ordered list store.
`timescale 1ns / 1ps

package ols_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 9;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_GET    = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    clear;
        logic    rd_get;
        logic    shift_init;
        logic    shift_step;
        logic    dec;
        logic    finish;
        logic    ret_data;
        status_t st;
    } ols_cmd_t;

    typedef struct packed {
        action_t act;
        logic    full;
        logic    beyond_end;
        logic    more;
    } ols_stat_t;

endpackage

[hw/rtl/ols_dp.sv]
// Datapath of the ordered list store: entry memory, count, shift pointers, result words.
`timescale 1ns / 1ps

module ols_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ols_pkg::ols_cmd_t            cmd,
    output ols_pkg::ols_stat_t           stat,
    input  logic [1:0]                   action,
    input  logic [ols_pkg::POS_W-1:0]    position,
    input  logic signed [ols_pkg::DATA_W-1:0] value,
    output logic                         done,
    output logic signed [ols_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                   status,
    output logic [ols_pkg::LEN_W-1:0]    length
);

    logic [ols_pkg::DATA_W-1:0] mem [ols_pkg::CAPACITY];

    ols_pkg::action_t               action_reg;
    logic [ols_pkg::POS_W-1:0]      pos_reg;
    logic [ols_pkg::DATA_W-1:0]     value_reg;
    logic [ols_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ols_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic                           wr_pend_reg;
    logic [ols_pkg::ADDR_W-1:0]     wr_addr_reg;
    logic [ols_pkg::DATA_W-1:0]     rdata_reg;
    logic                           done_reg;
    ols_pkg::status_t               status_reg;
    logic [ols_pkg::LEN_W-1:0]      len_reg;
    logic [ols_pkg::DATA_W-1:0]     rv_reg;

    logic                           mem_we;
    logic [ols_pkg::ADDR_W-1:0]     mem_waddr;
    logic [ols_pkg::DATA_W-1:0]     mem_wdata;
    logic                           mem_re;
    logic [ols_pkg::ADDR_W-1:0]     mem_raddr;
    logic [ols_pkg::CNT_W-1:0]      pos_ext;

    assign pos_ext = ols_pkg::CNT_W'(pos_reg);

    assign stat.act        = action_reg;
    assign stat.full       = (count_reg == ols_pkg::CNT_W'(ols_pkg::CAPACITY));
    assign stat.beyond_end = (pos_ext >= count_reg);
    assign stat.more       = (idx_reg < count_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rdata_reg;
        if (cmd.append)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[ols_pkg::ADDR_W-1:0];
            mem_wdata = value_reg;
        end
        else if (wr_pend_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        mem_re    = cmd.rd_get | cmd.shift_step;
        mem_raddr = cmd.rd_get ? ols_pkg::ADDR_W'(pos_reg) : idx_reg[ols_pkg::ADDR_W-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + ols_pkg::CNT_W'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - ols_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.shift_init)
        begin
            idx_next = pos_ext + ols_pkg::CNT_W'(1);
        end
        else if (cmd.shift_step)
        begin
            idx_next = idx_reg + ols_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            wr_pend_reg <= cmd.shift_step;
            done_reg    <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            action_reg <= ols_pkg::action_t'(action);
            pos_reg    <= position;
            value_reg  <= value;
        end
        if (cmd.shift_step)
        begin
            wr_addr_reg <= ols_pkg::ADDR_W'(idx_reg - ols_pkg::CNT_W'(1));
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.st;
            len_reg    <= ols_pkg::LEN_W'(count_next);
            rv_reg     <= cmd.ret_data ? rdata_reg : '0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign length     = len_reg;
    assign read_value = rv_reg;

endmodule

[hw/rtl/ols_ctrl.sv]
// Controller state machine of the ordered list store.
`timescale 1ns / 1ps

module ols_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ols_pkg::ols_stat_t      stat,
    output ols_pkg::ols_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_GETW   = 4'b0100,
        S_SHIFT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.st     = ols_pkg::ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.act)
                    ols_pkg::ACT_APPEND:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                        if (stat.full)
                        begin
                            cmd.st = ols_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    ols_pkg::ACT_REMOVE:
                    begin
                        if (stat.beyond_end)
                        begin
                            cmd.finish = 1'b1;
                            cmd.st     = ols_pkg::ST_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = S_SHIFT;
                        end
                    end
                    ols_pkg::ACT_GET:
                    begin
                        if (stat.beyond_end)
                        begin
                            cmd.finish = 1'b1;
                            cmd.st     = ols_pkg::ST_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_get = 1'b1;
                            state_next = S_GETW;
                        end
                    end
                    ols_pkg::ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_GETW:
            begin
                cmd.finish   = 1'b1;
                cmd.ret_data = 1'b1;
                state_next   = S_IDLE;
            end
            S_SHIFT:
            begin
                if (stat.more)
                begin
                    cmd.shift_step = 1'b1;
                end
                else
                begin
                    cmd.dec    = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hw/rtl/ordered_list_store_core.sv]
// Top level of the ordered list store: controller plus datapath.
// Append, clear and refused requests finish in the decide state; get passes through a read-wait state.
// Remove at position p moves each entry above p down by one, one entry per shift step,
// since the entry memory has a single write port and a single read port.
// One word at a time: start is taken again in the cycle done is shown; done is never held off.
// Reset (rst_n low, asynchronous) empties the list; entry contents stay unknown until written.
`timescale 1ns / 1ps

module ordered_list_store_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [ols_pkg::POS_W-1:0]           position,
    input  logic signed [ols_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic signed [ols_pkg::DATA_W-1:0]   read_value,
    output logic [1:0]                          status,
    output logic [ols_pkg::LEN_W-1:0]           length
);

    ols_pkg::ols_cmd_t  cmd;
    ols_pkg::ols_stat_t stat;

    ols_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ols_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .position   (position),
        .value      (value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

endmodule
